// ===== hdl/clni_pkg.sv =====
// ----------------------------------------------------------------------------
// clni_pkg - shared types and constants
// Phase codes, register indexes, request kinds and the init command table
// for the character LCD 4-bit bus interface.
// ----------------------------------------------------------------------------
package clni_pkg;

   // request kinds (req_tuser)
   localparam logic [1:0] KIND_TICK = 2'd0;
   localparam logic [1:0] KIND_CMD  = 2'd1;
   localparam logic [1:0] KIND_DATA = 2'd2;
   localparam logic [1:0] KIND_INIT = 2'd3;

   // register indexes
   localparam logic [1:0] CSR_ENABLE_PULSE = 2'd0;
   localparam logic [1:0] CSR_BYTE_WAIT    = 2'd1;
   localparam logic [1:0] CSR_POWER_UP     = 2'd2;

   // register reset values
   localparam logic [7:0]  ENABLE_PULSE_RST = 8'd1;
   localparam logic [15:0] BYTE_WAIT_RST    = 16'd2000;
   localparam logic [15:0] POWER_UP_RST     = 16'd20000;

   // sequencer phases
   localparam logic [2:0] PH_IDLE      = 3'd0;
   localparam logic [2:0] PH_POWER     = 3'd1;
   localparam logic [2:0] PH_HI_EN     = 3'd2;
   localparam logic [2:0] PH_HI_GAP    = 3'd3;
   localparam logic [2:0] PH_LO_EN     = 3'd4;
   localparam logic [2:0] PH_BYTE_WAIT = 3'd5;
   localparam logic [2:0] PH_INIT_WAIT = 3'd6;

   localparam logic [2:0] INIT_COUNT = 3'd6;

   typedef struct packed {
      logic [7:0]  enable_pulse_us;
      logic [15:0] byte_wait_us;
      logic [15:0] power_up_wait_us;
   } clni_cfg_type;

   typedef struct packed {
      logic       rejected;
      logic       busy_res;
      logic       en;
      logic       rw;
      logic       rs;
      logic [3:0] data_nibble;
   } clni_lines_type;

   function automatic logic [7:0] init_byte(input logic [2:0] step);
      logic [7:0] b;
      case (step)
         3'd0:    b = 8'h02;
         3'd1:    b = 8'h28;
         3'd2:    b = 8'h0C;
         3'd3:    b = 8'h01;
         3'd4:    b = 8'h06;
         3'd5:    b = 8'h80;
         default: b = 8'h00;
      endcase
      return b;
   endfunction

   function automatic logic [15:0] init_wait(input logic [2:0] step);
      logic [15:0] w;
      case (step)
         3'd0:    w = 16'd5000;
         3'd1:    w = 16'd1000;
         3'd2:    w = 16'd1000;
         3'd3:    w = 16'd2000;
         3'd4:    w = 16'd1000;
         3'd5:    w = 16'd1000;
         default: w = 16'd1;
      endcase
      return w;
   endfunction

endpackage

// ===== hdl/char_lcd_nibble_interface_unit.sv =====
// ----------------------------------------------------------------------------
// char_lcd_nibble_interface_unit - character LCD 4-bit bus interface
// Top level: register port, stream handshake and result register.
// ----------------------------------------------------------------------------
// Every input word (a 1 us tick, a command byte, a data byte or an init
// request) yields exactly one output word giving the display line levels
// after it. One word per cycle is taken and answered in the next cycle: the
// sequencer updates in the accept cycle and the line levels land in the
// output register, which keeps taking words as long as rsp_tready is high
// or the register is empty. Timing on the display side is counted in ticks,
// not clocks. Command, data and init requests sent while a byte or init
// sequence is running come back with rejected set and change nothing.
module char_lcd_nibble_interface_unit
   import clni_pkg::*;
#(
   parameter int WAIT_WIDTH = 17
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] byte_value
   input  logic [1:0]  req_tuser,   // [1:0] kind
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata    // [3:0] data_nibble, [4] rs, [5] rw, [6] en,
                                    // [7] busy_res, [8] rejected, rest zero
);

   clni_cfg_type   cfg_ff;
   clni_lines_type lines;
   clni_lines_type rsp_ff;
   logic           rsp_valid_ff;
   logic           accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.enable_pulse_us  <= ENABLE_PULSE_RST;
         cfg_ff.byte_wait_us     <= BYTE_WAIT_RST;
         cfg_ff.power_up_wait_us <= POWER_UP_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_ENABLE_PULSE: cfg_ff.enable_pulse_us  <= csr_wdata[7:0];
            CSR_BYTE_WAIT:    cfg_ff.byte_wait_us     <= csr_wdata;
            CSR_POWER_UP:     cfg_ff.power_up_wait_us <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   clni_seq #(
      .WAIT_WIDTH (WAIT_WIDTH)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .step       (accept),
      .kind       (req_tuser),
      .byte_value (req_tdata),
      .cfg        (cfg_ff),
      .lines      (lines)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_tready) begin
         rsp_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= lines;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_ff};

   // a dropped request only happens mid-sequence
   a_reject_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[8] |-> rsp_tdata[7])
      else $error("rejected word without busy");

   a_en_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[6] |-> rsp_tdata[7])
      else $error("enable high while idle");

   a_rw_low: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !rsp_tdata[5])
      else $error("rw driven high");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("output valid after reset");

endmodule

// ===== hdl/clni_seq.sv =====
// ----------------------------------------------------------------------------
// clni_seq - bus sequencer
// Holds phase, wait counter and the byte in flight; works out the next state
// and the line levels for one word per cycle in which step is high.
// ----------------------------------------------------------------------------
module clni_seq
   import clni_pkg::*;
#(
   parameter int WAIT_WIDTH = 17
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           step,
   input  logic [1:0]     kind,
   input  logic [7:0]     byte_value,
   input  clni_cfg_type   cfg,
   output clni_lines_type lines
);

   logic [2:0]            phase_ff, phase_in;
   logic [WAIT_WIDTH-1:0] wait_ff, wait_in;
   logic [7:0]            byte_ff, byte_in;
   logic                  rs_ff, rs_in;
   logic [2:0]            init_step_ff, init_step_in;
   logic                  init_active_ff, init_active_in;
   logic                  rej;
   logic [2:0]            step_inc;
   logic                  hi, en;

   // zero counts as one tick, long values saturate
   function automatic logic [WAIT_WIDTH-1:0] wait_len(input logic [15:0] v);
      logic [WAIT_WIDTH-1:0] r;
      if (v == 16'd0) begin
         r = WAIT_WIDTH'(1);
      end else if ((WAIT_WIDTH < 16) && ((v >> WAIT_WIDTH) != 16'd0)) begin
         r = '1;
      end else begin
         r = WAIT_WIDTH'(v);
      end
      return r;
   endfunction

   assign step_inc = init_step_ff + 3'd1;

   always_comb begin
      phase_in       = phase_ff;
      wait_in        = wait_ff;
      byte_in        = byte_ff;
      rs_in          = rs_ff;
      init_step_in   = init_step_ff;
      init_active_in = init_active_ff;
      rej            = 1'b0;
      if (step) begin
         if (kind == KIND_TICK) begin
            if (phase_ff != PH_IDLE) begin
               if (wait_ff > WAIT_WIDTH'(1)) begin
                  wait_in = wait_ff - WAIT_WIDTH'(1);
               end else begin
                  case (phase_ff)
                     PH_POWER: begin
                        init_step_in = 3'd0;
                        byte_in      = init_byte(3'd0);
                        rs_in        = 1'b0;
                        phase_in     = PH_HI_EN;
                        wait_in      = wait_len({8'd0, cfg.enable_pulse_us});
                     end
                     PH_HI_EN: begin
                        phase_in = PH_HI_GAP;
                        wait_in  = wait_len({8'd0, cfg.enable_pulse_us});
                     end
                     PH_HI_GAP: begin
                        phase_in = PH_LO_EN;
                        wait_in  = wait_len({8'd0, cfg.enable_pulse_us});
                     end
                     PH_LO_EN: begin
                        phase_in = PH_BYTE_WAIT;
                        wait_in  = wait_len(cfg.byte_wait_us);
                     end
                     PH_BYTE_WAIT: begin
                        if (init_active_ff && (init_step_ff < INIT_COUNT)) begin
                           phase_in = PH_INIT_WAIT;
                           wait_in  = wait_len(init_wait(init_step_ff));
                        end else begin
                           init_active_in = 1'b0;
                           init_step_in   = 3'd0;
                           phase_in       = PH_IDLE;
                           wait_in        = '0;
                        end
                     end
                     PH_INIT_WAIT: begin
                        if (step_inc < INIT_COUNT) begin
                           init_step_in = step_inc;
                           byte_in      = init_byte(step_inc);
                           rs_in        = 1'b0;
                           phase_in     = PH_HI_EN;
                           wait_in      = wait_len({8'd0, cfg.enable_pulse_us});
                        end else begin
                           init_active_in = 1'b0;
                           init_step_in   = 3'd0;
                           phase_in       = PH_IDLE;
                           wait_in        = '0;
                        end
                     end
                     default: begin
                        phase_in = PH_IDLE;
                        wait_in  = '0;
                     end
                  endcase
               end
            end
         end else if (phase_ff != PH_IDLE) begin
            rej = 1'b1;
         end else if (kind == KIND_INIT) begin
            init_active_in = 1'b1;
            init_step_in   = 3'd0;
            phase_in       = PH_POWER;
            wait_in        = wait_len(cfg.power_up_wait_us);
         end else begin
            byte_in  = byte_value;
            rs_in    = (kind == KIND_DATA);
            phase_in = PH_HI_EN;
            wait_in  = wait_len({8'd0, cfg.enable_pulse_us});
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_IDLE;
         wait_ff        <= '0;
         byte_ff        <= 8'd0;
         rs_ff          <= 1'b0;
         init_step_ff   <= 3'd0;
         init_active_ff <= 1'b0;
      end else begin
         phase_ff       <= phase_in;
         wait_ff        <= wait_in;
         byte_ff        <= byte_in;
         rs_ff          <= rs_in;
         init_step_ff   <= init_step_in;
         init_active_ff <= init_active_in;
      end
   end

   // line levels as they stand after this word
   assign hi = (phase_in == PH_HI_EN) || (phase_in == PH_HI_GAP);
   assign en = (phase_in == PH_HI_EN) || (phase_in == PH_LO_EN);

   always_comb begin
      lines.data_nibble = hi ? byte_in[7:4] : byte_in[3:0];
      lines.rs          = rs_in;
      lines.rw          = 1'b0;
      lines.en          = en;
      lines.busy_res    = (phase_in != PH_IDLE);
      lines.rejected    = rej;
   end

endmodule
